// File: design/ivt_pkg.sv
package ivt_pkg;

	localparam int KEY_BITS   = 32;
	localparam int VALUE_BITS = 8;
	localparam int COUNT_BITS = 7;
	localparam int STAT_BITS  = 2;

	localparam logic [STAT_BITS-1:0] ST_DONE  = 2'd0;
	localparam logic [STAT_BITS-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_BITS-1:0] ST_FULL  = 2'd2;

	localparam logic OP_ASSIGN = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	typedef struct packed {
		logic                        op;
		logic signed [KEY_BITS-1:0]  key_begin;
		logic signed [KEY_BITS-1:0]  key_end;
		logic [VALUE_BITS-1:0]       new_value;
	} in_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0] read_value;
		logic [STAT_BITS-1:0]  status;
		logic [COUNT_BITS-1:0] entry_count;
	} out_t;

endpackage

// File: design/interval_range_value_table_unit.sv
// sequencing: each stored breakpoint is read and compared in turn; an assign also
// pushes the begin, end and kept keys, and an empty assign interval skips the scan
// throughput: one transaction at a time, set by a sequential scan of the breakpoint
// memory through one read port and a shared set of key compares
// reset: asynchronous active low; breakpoint count and default value clear, memory
// contents stay undefined and are never read before written
module interval_range_value_table_unit #(
	parameter int CAPACITY = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  ivt_pkg::in_t in_data,
	output logic         out_valid,
	input  logic         out_stall,
	output ivt_pkg::out_t out_data,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [1:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int KB = ivt_pkg::KEY_BITS;
	localparam int VB = ivt_pkg::VALUE_BITS;
	localparam int AW = $clog2(CAPACITY);
	localparam int IW = $clog2(CAPACITY + 1);
	localparam int CW = $clog2(CAPACITY + 2);
	localparam logic [KB-1:0] SIGN = {1'b1, {(KB-1){1'b0}}};

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RD   = 4'd1;
	localparam logic [3:0] S_PB   = 4'd2;
	localparam logic [3:0] S_PE   = 4'd3;
	localparam logic [3:0] S_PK   = 4'd4;
	localparam logic [3:0] S_FB   = 4'd5;
	localparam logic [3:0] S_FE   = 4'd6;
	localparam logic [3:0] S_DONE = 4'd7;

	logic [3:0]    state_q;
	logic          cur_q;
	logic [IW-1:0] n_q, i_q;
	logic [CW-1:0] cnt_q;
	logic          op_q, empty_q, bdone_q, edone_q;
	logic [KB-1:0] kb_q, ke_q;
	logic [VB-1:0] nv_q, last_q, endv_q, dflt_q;
	logic          out_valid_q;
	ivt_pkg::out_t out_q;

	// apb register
	assign pready = 1'b1;
	assign prdata = 32'(dflt_q);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dflt_q <= '0;
		end else if (psel && penable && pwrite) begin
			dflt_q <= pwdata[VB-1:0];
		end
	end

	// breakpoint banks, read current, write the other
	logic [KB+VB-1:0] rd0, rd1, rdata, wdata;
	logic             wr;
	ivt_ram #(.WIDTH(KB + VB), .DEPTH(CAPACITY)) u_bank0 (
		.clk(clk), .we(wr && cur_q), .waddr(cnt_q[AW-1:0]), .wdata(wdata),
		.raddr(i_q[AW-1:0]), .rdata(rd0)
	);
	ivt_ram #(.WIDTH(KB + VB), .DEPTH(CAPACITY)) u_bank1 (
		.clk(clk), .we(wr && !cur_q), .waddr(cnt_q[AW-1:0]), .wdata(wdata),
		.raddr(i_q[AW-1:0]), .rdata(rd1)
	);
	assign rdata = cur_q ? rd1 : rd0;

	logic [KB-1:0] rk;
	logic [VB-1:0] rv;
	assign rk = rdata[KB+VB-1:VB];
	assign rv = rdata[VB-1:0];

	// shared compares
	logic lt_b, le_c, gt_e;
	assign lt_b = rk < kb_q;
	assign le_c = rk <= (op_q ? kb_q : ke_q);
	assign gt_e = rk > ke_q;

	// push request of the current step
	logic          req, fresh;
	logic [KB-1:0] pk;
	logic [VB-1:0] pv;
	always_comb begin
		req = 1'b0;
		pk  = kb_q;
		pv  = nv_q;
		case (state_q)
			S_PB: req = (op_q == ivt_pkg::OP_ASSIGN) && !lt_b && !bdone_q;
			S_PE: begin
				req = (op_q == ivt_pkg::OP_ASSIGN) && gt_e && !edone_q;
				pk  = ke_q;
				pv  = endv_q;
			end
			S_PK: begin
				req = (op_q == ivt_pkg::OP_ASSIGN) && (lt_b || gt_e);
				pk  = rk;
				pv  = rv;
			end
			S_FB: req = !bdone_q;
			S_FE: begin
				req = !edone_q;
				pk  = ke_q;
				pv  = endv_q;
			end
			default: req = 1'b0;
		endcase
	end
	assign fresh = req && (pv != last_q);
	assign wr    = fresh && (cnt_q < CW'(CAPACITY));
	assign wdata = {pk, pv};

	logic last_entry;
	assign last_entry = (i_q + IW'(1)) >= n_q;

	logic over;
	assign over = cnt_q > CW'(CAPACITY);

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cur_q       <= 1'b0;
			n_q         <= '0;
			i_q         <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			if (fresh) begin
				last_q <= pv;
				if (cnt_q <= CW'(CAPACITY)) begin
					cnt_q <= cnt_q + CW'(1);
				end
			end
			case (state_q)
				S_IDLE: if (in_valid) begin
					op_q    <= in_data.op;
					kb_q    <= in_data.key_begin ^ SIGN;
					ke_q    <= in_data.key_end ^ SIGN;
					nv_q    <= in_data.new_value;
					last_q  <= dflt_q;
					endv_q  <= dflt_q;
					bdone_q <= 1'b0;
					edone_q <= 1'b0;
					cnt_q   <= '0;
					i_q     <= '0;
					empty_q <= (in_data.op == ivt_pkg::OP_ASSIGN) &&
					           !(in_data.key_begin < in_data.key_end);
					if ((in_data.op == ivt_pkg::OP_ASSIGN) &&
					    !(in_data.key_begin < in_data.key_end)) begin
						state_q <= S_DONE;
					end else if (n_q == '0) begin
						state_q <= (in_data.op == ivt_pkg::OP_LOOKUP) ? S_DONE : S_FB;
					end else begin
						state_q <= S_RD;
					end
				end
				S_RD: state_q <= S_PB;
				S_PB: begin
					if (le_c) begin
						endv_q <= rv;
					end
					if (req) begin
						bdone_q <= 1'b1;
					end
					if (op_q == ivt_pkg::OP_LOOKUP) begin
						i_q     <= i_q + IW'(1);
						state_q <= last_entry ? S_DONE : S_RD;
					end else begin
						state_q <= S_PE;
					end
				end
				S_PE: begin
					if (req) begin
						edone_q <= 1'b1;
					end
					state_q <= S_PK;
				end
				S_PK: begin
					i_q     <= i_q + IW'(1);
					state_q <= last_entry ? S_FB : S_RD;
				end
				S_FB: begin
					if (req) begin
						bdone_q <= 1'b1;
					end
					state_q <= S_FE;
				end
				S_FE: begin
					if (req) begin
						edone_q <= 1'b1;
					end
					state_q <= S_DONE;
				end
				S_DONE: if (!out_valid_q || !out_stall) begin
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
					out_q.read_value <= (op_q == ivt_pkg::OP_LOOKUP) ? endv_q : '0;
					if (op_q == ivt_pkg::OP_LOOKUP) begin
						out_q.status      <= ivt_pkg::ST_DONE;
						out_q.entry_count <= ivt_pkg::COUNT_BITS'(n_q);
					end else if (empty_q) begin
						out_q.status      <= ivt_pkg::ST_EMPTY;
						out_q.entry_count <= ivt_pkg::COUNT_BITS'(n_q);
					end else if (over) begin
						out_q.status      <= ivt_pkg::ST_FULL;
						out_q.entry_count <= ivt_pkg::COUNT_BITS'(n_q);
					end else begin
						out_q.status      <= ivt_pkg::ST_DONE;
						out_q.entry_count <= ivt_pkg::COUNT_BITS'(cnt_q);
						n_q               <= IW'(cnt_q);
						cur_q             <= !cur_q;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: design/ivt_ram.sv
module ivt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// single write port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
